// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helpers included by lrpa_walker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrpa_pkg.sv =====
// ---------------------------------------------------------------------------
// lrpa_pkg
// shared types and constants of the line raster pixel address block
// ---------------------------------------------------------------------------
package lrpa_pkg;

    typedef enum logic [2:0] {
        CFG_FRAME_BASE  = 3'd0,
        CFG_X_RES       = 3'd1,
        CFG_Y_RES       = 3'd2,
        CFG_X_OFFSET    = 3'd3,
        CFG_Y_OFFSET    = 3'd4,
        CFG_BYTES_PIXEL = 3'd5,
        CFG_LINE_PITCH  = 3'd6
    } cfg_index_t;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [31:0] RST_FRAME_BASE  = 32'd0;
    localparam logic [11:0] RST_X_RES       = 12'd640;
    localparam logic [11:0] RST_Y_RES       = 12'd480;
    localparam logic [11:0] RST_X_OFFSET    = 12'd0;
    localparam logic [11:0] RST_Y_OFFSET    = 12'd0;
    localparam logic [3:0]  RST_BYTES_PIXEL = 4'd4;
    localparam logic [15:0] RST_LINE_PITCH  = 16'd2560;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [11:0] x_res;
        logic [11:0] y_res;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic [3:0]  bytes_pixel;
        logic [15:0] line_pitch;
    } cfg_regs_t;

    // walker status seen by the output stage
    typedef struct packed {
        logic on_line;
        logic last;
    } pix_ctrl_t;

endpackage

// ===== design/line_raster_pixel_address.sv =====
// ---------------------------------------------------------------------------
// line_raster_pixel_address
// all-octant line walker with clipping and framebuffer address generation
//
// channel   dir  handshake            payload
// config    in   cfg_we               cfg_index, cfg_data
// input     in   in_valid / in_ready  action, x_start, y_start, x_end, y_end, color
// output    out  out_valid / out_ready pixel_valid, pixel_x, pixel_y, visible,
//                                     pixel_address, pixel_color, last
//
// one item per cycle while the output is not stalled; a step word appears at the output the cycle after acceptance
// the walker state and the result register form the only pipeline stage
// a load word updates the walker and produces no output word
// input stalls only while the result register holds a word not yet taken
// reset clears the walker's active flag and the result valid, and restores the
// register defaults
// ---------------------------------------------------------------------------
module line_raster_pixel_address
    import lrpa_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [31:0]                  color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         pixel_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         visible,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic [31:0]                  pixel_color,
    output logic                         last
);

    cfg_regs_t cfg_reg, cfg_next;

    logic                         accept, load, step;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [31:0]                  line_color;
    pix_ctrl_t                    ctrl;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_BASE:  cfg_next.frame_base  = cfg_data;
                CFG_X_RES:       cfg_next.x_res       = cfg_data[11:0];
                CFG_Y_RES:       cfg_next.y_res       = cfg_data[11:0];
                CFG_X_OFFSET:    cfg_next.x_offset    = cfg_data[11:0];
                CFG_Y_OFFSET:    cfg_next.y_offset    = cfg_data[11:0];
                CFG_BYTES_PIXEL: cfg_next.bytes_pixel = cfg_data[3:0];
                CFG_LINE_PITCH:  cfg_next.line_pitch  = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base  <= RST_FRAME_BASE;
            cfg_reg.x_res       <= RST_X_RES;
            cfg_reg.y_res       <= RST_Y_RES;
            cfg_reg.x_offset    <= RST_X_OFFSET;
            cfg_reg.y_offset    <= RST_Y_OFFSET;
            cfg_reg.bytes_pixel <= RST_BYTES_PIXEL;
            cfg_reg.line_pitch  <= RST_LINE_PITCH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;
    assign load     = accept && (action == ACT_LOAD);
    assign step     = accept && (action == ACT_STEP);

    lrpa_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .step       (step),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .color      (color),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .line_color (line_color),
        .ctrl       (ctrl)
    );

    lrpa_pixel #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_pixel (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture       (step),
        .out_ready     (out_ready),
        .ctrl          (ctrl),
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .line_color    (line_color),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .visible       (visible),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last          (last)
    );

endmodule

// ===== design/lrpa_walker.sv =====
// ---------------------------------------------------------------------------
// lrpa_walker
// bresenham state: position, endpoints, direction, spans, error term and color, one step a cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lrpa_walker
    import lrpa_pkg::*;
#(
    parameter int COORD_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         step,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [31:0]                  color,
    output logic signed [COORD_BITS-1:0] cur_x,
    output logic signed [COORD_BITS-1:0] cur_y,
    output logic [31:0]                  line_color,
    output pix_ctrl_t                    ctrl
);

    localparam int ERRW = COORD_BITS + 3;

    logic                         active_reg, active_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] end_x_reg, end_x_next;
    logic signed [COORD_BITS-1:0] end_y_reg, end_y_next;
    logic                         dir_x_neg_reg, dir_x_neg_next;
    logic                         dir_y_neg_reg, dir_y_neg_next;
    logic [COORD_BITS-1:0]        span_x_reg, span_x_next;
    logic [COORD_BITS-1:0]        span_y_reg, span_y_next;
    logic signed [ERRW-1:0]       err_reg, err_next;
    logic [31:0]                  color_reg, color_next;

    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0]        load_span_x, load_span_y;
    logic signed [ERRW-1:0]       e2, neg_sy, pos_sx;
    logic                         at_end, move_x, move_y;

    assign at_end = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);

    always_comb
    begin
        dx = (COORD_BITS+1)'(x_end) - (COORD_BITS+1)'(x_start);
        dy = (COORD_BITS+1)'(y_end) - (COORD_BITS+1)'(y_start);
        load_span_x = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        load_span_y = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

        e2     = err_reg <<< 1;
        neg_sy = -$signed(ERRW'(span_y_reg));
        pos_sx = $signed(ERRW'(span_x_reg));
        move_x = (e2 >= neg_sy);
        move_y = (e2 <= pos_sx);

        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        err_next       = err_reg;
        color_next     = color_reg;

        if (load)
        begin
            active_next    = 1'b1;
            cur_x_next     = x_start;
            cur_y_next     = y_start;
            end_x_next     = x_end;
            end_y_next     = y_end;
            dir_x_neg_next = dx[COORD_BITS] || (dx == '0);
            dir_y_neg_next = dy[COORD_BITS] || (dy == '0);
            span_x_next    = load_span_x;
            span_y_next    = load_span_y;
            err_next       = $signed(ERRW'(load_span_x)) - $signed(ERRW'(load_span_y));
            color_next     = color;
        end
        else if (step && active_reg)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + (move_x ? neg_sy : '0) + (move_y ? pos_sx : '0);
                if (move_x)
                begin
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                               : cur_x_reg + COORD_BITS'(1);
                end
                if (move_y)
                begin
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                               : cur_y_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            err_reg       <= '0;
            color_reg     <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            err_reg       <= err_next;
            color_reg     <= color_next;
        end
    end

    assign cur_x        = cur_x_reg;
    assign cur_y        = cur_y_reg;
    assign line_color   = color_reg;
    assign ctrl.on_line = active_reg;
    assign ctrl.last    = at_end;

    `ASSERT_NEXT(a_load_arms, clk, rst_n, load, active_reg, "load did not arm the walker")
    `ASSERT_SAME(a_idle_cause, clk, rst_n, $fell(active_reg),
        $past(step) && $past(at_end) && !$past(load), "walker went idle before end point")
    `ASSERT_NEXT(a_step_moves, clk, rst_n, step && !load && active_reg && !at_end,
        (cur_x_reg != $past(cur_x_reg)) || (cur_y_reg != $past(cur_y_reg)),
        "step did not advance the walker")

endmodule

// ===== design/lrpa_pixel.sv =====
// ---------------------------------------------------------------------------
// lrpa_pixel
// clip test and framebuffer address of the current pixel, result register
// ---------------------------------------------------------------------------
module lrpa_pixel
    import lrpa_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         capture,
    input  logic                         out_ready,
    input  pix_ctrl_t                    ctrl,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic [31:0]                  line_color,
    input  cfg_regs_t                    cfg,
    output logic                         out_valid,
    output logic                         pixel_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         visible,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic [31:0]                  pixel_color,
    output logic                         last
);

    localparam int AXW  = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
    localparam int VW   = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int WIDE = ADDR_BITS + AXW + 17;

    logic signed [AXW-1:0]    ax, ay;
    logic signed [AXW-1:0]    x_off, y_off;
    logic signed [4:0]        bpp;
    logic signed [16:0]       pitch;
    logic signed [AXW+4:0]    prod_x;
    logic signed [AXW+16:0]   prod_y;
    logic signed [WIDE-1:0]   prod_x_w, prod_y_w;
    logic [WIDE-1:0]          base_w;
    logic [ADDR_BITS-1:0]     addr;
    logic [VW-1:0]            ux, uy;
    logic                     vis;

    logic                         valid_reg, valid_next;
    logic                         pix_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic                         vis_reg, last_reg;
    logic [ADDR_BITS-1:0]         addr_reg;
    logic [31:0]                  color_reg;

    always_comb
    begin
        x_off = $signed(AXW'(cfg.x_offset));
        y_off = $signed(AXW'(cfg.y_offset));
        ax    = AXW'(cur_x) + x_off;
        ay    = AXW'(cur_y) + y_off;
        bpp   = $signed({1'b0, cfg.bytes_pixel});
        pitch = $signed({1'b0, cfg.line_pitch});

        prod_x   = ax * bpp;
        prod_y   = ay * pitch;
        prod_x_w = WIDE'(prod_x);
        prod_y_w = WIDE'(prod_y);
        base_w   = WIDE'(cfg.frame_base);
        // everything wraps at the address width
        addr = base_w[ADDR_BITS-1:0] + prod_x_w[ADDR_BITS-1:0] + prod_y_w[ADDR_BITS-1:0];

        ux  = VW'($unsigned(cur_x));
        uy  = VW'($unsigned(cur_y));
        vis = !cur_x[COORD_BITS-1] && (ux < VW'(cfg.x_res)) &&
              !cur_y[COORD_BITS-1] && (uy < VW'(cfg.y_res));

        valid_next = valid_reg;
        if (capture)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // an idle walker gives an all-zero word
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            pix_valid_reg <= ctrl.on_line;
            x_reg         <= ctrl.on_line ? cur_x : '0;
            y_reg         <= ctrl.on_line ? cur_y : '0;
            vis_reg       <= ctrl.on_line && vis;
            addr_reg      <= ctrl.on_line ? addr : '0;
            color_reg     <= ctrl.on_line ? line_color : '0;
            last_reg      <= ctrl.on_line && ctrl.last;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_valid   = pix_valid_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign visible       = vis_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign last          = last_reg;

endmodule

// ===== tb/line_raster_pixel_address_checker.sv =====
// ----------------------------------------------------------------------------
// line_raster_pixel_address_checker
// Watches the config port and both channels of the line raster block. Keeps
// its own copy of the walker and the raster registers, predicts every pixel
// word, and compares each word taken from the output field by field.
// ----------------------------------------------------------------------------
module line_raster_pixel_address_checker
    import lrpa_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [31:0]                  color,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         pixel_valid,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    input  logic                         visible,
    input  logic [ADDR_BITS-1:0]         pixel_address,
    input  logic [31:0]                  pixel_color,
    input  logic                         last,
    output int                           outstanding,
    output int                           failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         visible;
        logic [ADDR_BITS-1:0]         pixel_address;
        logic [31:0]                  pixel_color;
        logic                         last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];

    cfg_regs_t                    raster_cfg;
    logic                         walking;
    logic signed [COORD_BITS-1:0] pos_x, pos_y, stop_x, stop_y;
    logic                         neg_x, neg_y;
    int                           run_x, run_y, err_acc;
    logic [31:0]                  hue;

    function automatic void restore_defaults();
        raster_cfg.frame_base  = RST_FRAME_BASE;
        raster_cfg.x_res       = RST_X_RES;
        raster_cfg.y_res       = RST_Y_RES;
        raster_cfg.x_offset    = RST_X_OFFSET;
        raster_cfg.y_offset    = RST_Y_OFFSET;
        raster_cfg.bytes_pixel = RST_BYTES_PIXEL;
        raster_cfg.line_pitch  = RST_LINE_PITCH;
        walking = 1'b0;
        pos_x   = '0;
        pos_y   = '0;
        stop_x  = '0;
        stop_y  = '0;
        neg_x   = 1'b0;
        neg_y   = 1'b0;
        run_x   = 0;
        run_y   = 0;
        err_acc = 0;
        hue     = '0;
    endfunction

    function automatic void write_raster_reg(logic [2:0] idx, logic [31:0] val);
        case (cfg_index_t'(idx))
            CFG_FRAME_BASE:  raster_cfg.frame_base  = val;
            CFG_X_RES:       raster_cfg.x_res       = val[11:0];
            CFG_Y_RES:       raster_cfg.y_res       = val[11:0];
            CFG_X_OFFSET:    raster_cfg.x_offset    = val[11:0];
            CFG_Y_OFFSET:    raster_cfg.y_offset    = val[11:0];
            CFG_BYTES_PIXEL: raster_cfg.bytes_pixel = val[3:0];
            CFG_LINE_PITCH:  raster_cfg.line_pitch  = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic void arm_walker();
        int x0, y0, x1, y1;
        x0 = x_start;
        y0 = y_start;
        x1 = x_end;
        y1 = y_end;
        pos_x   = x_start;
        pos_y   = y_start;
        stop_x  = x_end;
        stop_y  = y_end;
        neg_x   = !(x0 < x1);
        neg_y   = !(y0 < y1);
        run_x   = (x1 > x0) ? x1 - x0 : x0 - x1;
        run_y   = (y1 > y0) ? y1 - y0 : y0 - y1;
        err_acc = run_x - run_y;
        hue     = color;
        walking = 1'b1;
    endfunction

    // current pixel, then one bresenham step
    function automatic pixel_word_t emit_pixel();
        pixel_word_t          w;
        int                   cx, cy, xr, yr, e2;
        logic [ADDR_BITS-1:0] ax, ay;
        w = '0;
        if (!walking)
            return w;
        cx = pos_x;
        cy = pos_y;
        xr = raster_cfg.x_res;
        yr = raster_cfg.y_res;
        ax = ADDR_BITS'(cx) + raster_cfg.x_offset;
        ay = ADDR_BITS'(cy) + raster_cfg.y_offset;
        w.pixel_valid   = 1'b1;
        w.pixel_x       = pos_x;
        w.pixel_y       = pos_y;
        w.visible       = (cx >= 0) && (cx < xr) && (cy >= 0) && (cy < yr);
        w.pixel_address = raster_cfg.frame_base + ax * raster_cfg.bytes_pixel
                          + ay * raster_cfg.line_pitch;
        w.pixel_color   = hue;
        w.last          = (pos_x == stop_x) && (pos_y == stop_y);
        if (w.last) begin
            walking = 1'b0;
        end
        else begin
            e2 = 2 * err_acc;
            if (e2 >= -run_y) begin
                err_acc = err_acc - run_y;
                pos_x   = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            end
            if (e2 <= run_x) begin
                err_acc = err_acc + run_x;
                pos_y   = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
            end
        end
        return w;
    endfunction

    function automatic void compare_pixel();
        pixel_word_t w;
        if (expected_pixels.size() == 0) begin
            $error("unexpected pixel word: x %0d y %0d", pixel_x, pixel_y);
            failures++;
            return;
        end
        w = expected_pixels.pop_front();
        if (pixel_valid !== w.pixel_valid) begin
            $error("pixel_valid: expected %0d, actual %0d", w.pixel_valid, pixel_valid);
            failures++;
        end
        if (pixel_x !== w.pixel_x) begin
            $error("pixel_x: expected %0d, actual %0d", w.pixel_x, pixel_x);
            failures++;
        end
        if (pixel_y !== w.pixel_y) begin
            $error("pixel_y: expected %0d, actual %0d", w.pixel_y, pixel_y);
            failures++;
        end
        if (visible !== w.visible) begin
            $error("visible: expected %0d, actual %0d", w.visible, visible);
            failures++;
        end
        if (pixel_address !== w.pixel_address) begin
            $error("pixel_address: expected %h, actual %h", w.pixel_address, pixel_address);
            failures++;
        end
        if (pixel_color !== w.pixel_color) begin
            $error("pixel_color: expected %h, actual %h", w.pixel_color, pixel_color);
            failures++;
        end
        if (last !== w.last) begin
            $error("last: expected %0d, actual %0d", w.last, last);
            failures++;
        end
    endfunction

    initial begin
        failures    = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restore_defaults();
            expected_pixels.delete();
            outstanding = 0;
        end
        else begin
            if (cfg_we)
                write_raster_reg(cfg_index, cfg_data);
            // output side first: a word leaving now was predicted earlier
            if (out_valid && out_ready)
                compare_pixel();
            if (in_valid && in_ready) begin
                if (action == ACT_LOAD)
                    arm_walker();
                else
                    expected_pixels.push_back(emit_pixel());
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

// ===== tb/line_raster_pixel_address_tb.sv =====
// ----------------------------------------------------------------------------
// line_raster_pixel_address_tb
// Drives load and step words into the line raster block under several raster
// register settings, extremes included, with random gaps on the input and
// random stalls on the output. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module line_raster_pixel_address_tb;
    import lrpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = 13;
    localparam int ADDR_BITS   = 32;
    localparam int COORD_MIN   = -4096;
    localparam int COORD_MAX   = 4095;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 220;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [2:0]                   cfg_index = '0;
    logic [31:0]                  cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         action = ACT_LOAD;
    logic signed [COORD_BITS-1:0] x_start = '0;
    logic signed [COORD_BITS-1:0] y_start = '0;
    logic signed [COORD_BITS-1:0] x_end = '0;
    logic signed [COORD_BITS-1:0] y_end = '0;
    logic [31:0]                  color = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         visible;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [31:0]                  pixel_color;
    logic                         last;

    int outstanding;
    int failures;
    int words_sent = 0;
    bit steady = 1'b0;

    line_raster_pixel_address #(
        .COORD_BITS(COORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .color        (color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_valid  (pixel_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .visible      (visible),
        .pixel_address(pixel_address),
        .pixel_color  (pixel_color),
        .last         (last)
    );

    line_raster_pixel_address_checker #(
        .COORD_BITS(COORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .color        (color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_valid  (pixel_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .visible      (visible),
        .pixel_address(pixel_address),
        .pixel_color  (pixel_color),
        .last         (last),
        .outstanding  (outstanding),
        .failures     (failures)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // output back-pressure
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return int'($urandom_range(8191)) - 4096;
        if (r < 80)
            return int'($urandom_range(700)) - 30;
        if (r < 90)
            return COORD_MIN + int'($urandom_range(8));
        return COORD_MAX - int'($urandom_range(8));
    endfunction

    task automatic send_word(input logic act, input int xs, input int ys, input int xe,
                             input int ye, input logic [31:0] col);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        x_start  <= xs[COORD_BITS-1:0];
        y_start  <= ys[COORD_BITS-1:0];
        x_end    <= xe[COORD_BITS-1:0];
        y_end    <= ye[COORD_BITS-1:0];
        color    <= col;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // coordinate fields carry junk on a step word
    task automatic send_step();
        send_word(ACT_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_step();
    endtask

    // hold off until every pixel word is back, then let the walker settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_raster(input logic [31:0] base, input logic [11:0] xr,
                                input logic [11:0] yr, input logic [11:0] xo,
                                input logic [11:0] yo, input logic [3:0] bpp,
                                input logic [15:0] pitch);
        write_reg(CFG_FRAME_BASE, base);
        write_reg(CFG_X_RES, {20'd0, xr});
        write_reg(CFG_Y_RES, {20'd0, yr});
        write_reg(CFG_X_OFFSET, {20'd0, xo});
        write_reg(CFG_Y_OFFSET, {20'd0, yo});
        write_reg(CFG_BYTES_PIXEL, {28'd0, bpp});
        write_reg(CFG_LINE_PITCH, {16'd0, pitch});
    endtask

    // mostly whole lines, some cut short by the next load, some long ones truncated
    task automatic random_line();
        int r, xs, ys, xe, ye, len, n;
        r  = $urandom_range(99);
        xs = pick_coord();
        ys = pick_coord();
        if (r < 10) begin
            xe = pick_coord();
            ye = pick_coord();
        end
        else begin
            xe = clamp_coord(xs + int'($urandom_range(40)) - 20);
            ye = clamp_coord(ys + int'($urandom_range(40)) - 20);
        end
        send_word(ACT_LOAD, xs, ys, xe, ye, $urandom);
        len = ((iabs(xe - xs) > iabs(ye - ys)) ? iabs(xe - xs) : iabs(ye - ys)) + 1;
        if (r < 10)
            n = $urandom_range(1, 30);
        else if (r < 30)
            n = $urandom_range(0, len);
        else
            n = len + (($urandom_range(3) == 0) ? int'($urandom_range(1, 2)) : 0);
        send_steps(n);
    endtask

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [3:0]  bpp;
        logic [11:0] xr, yr;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset defaults
        send_step();
        send_word(ACT_LOAD, 5, 5, 5, 5, 32'hFFFF_FFFF);
        send_step();
        send_step();
        send_word(ACT_LOAD, 0, 0, 3, 1, 32'h0000_0000);
        send_steps(4);
        send_word(ACT_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hA5A5_A5A5);
        send_steps(3);
        send_word(ACT_LOAD, COORD_MAX, COORD_MIN, COORD_MAX - 5, COORD_MIN + 2,
                  32'h5A5A_5A5A);
        send_steps(6);
        send_word(ACT_LOAD, 641, 481, 638, 478, 32'h1234_5678);
        send_steps(4);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            steady = 1'b0;
            case (phase)
                0: write_raster(32'hFFFF_FFFF, 12'd0, 12'd0, 12'd4095, 12'd4095, 4'd15,
                                16'hFFFF);
                1: begin
                    write_raster(32'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 4'd1, 16'd1);
                    steady = 1'b1;
                end
                2: write_raster(32'h0000_0000, 12'd1, 12'd1, 12'd0, 12'd0, 4'd0, 16'd0);
                default: begin
                    bpp = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(1, 8));
                    xr  = 12'($urandom_range(1, 4095));
                    yr  = 12'($urandom_range(1, 4095));
                    if (phase == 3)
                        xr = 12'($urandom_range(300, 1000));
                    write_raster($urandom, xr, yr, 12'($urandom_range(4095)),
                                 12'($urandom_range(4095)), bpp,
                                 16'($urandom_range(65535)));
                end
            endcase
            while (words_sent < 25 + (phase + 1) * PHASE_WORDS)
                random_line();
        end
        steady = 1'b0;

        drain();
        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
